@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files; nir_queue.sv uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ hw/rtl/nir_pkg.sv @@
`timescale 1ns / 1ps
package nir_pkg;
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_RISE = 2'd1,
        ACT_FALL = 2'd2,
        ACT_SCAN = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        EVT_TICK,
        EVT_RISE,
        EVT_ZERO,
        EVT_ONE,
        EVT_REPEAT,
        EVT_LEADER,
        EVT_FALL_OTHER,
        EVT_SCAN
    } t_evt;

    typedef enum logic {
        CFG_DEV_ADDR = 1'b0,
        CFG_TIMEOUT  = 1'b1
    } t_cfg_idx;

    localparam int unsigned PULSE_W = 14;
    localparam int unsigned CFG_W   = 8;

    localparam logic [PULSE_W-1:0] ZERO_LO   = 14'd300;
    localparam logic [PULSE_W-1:0] ZERO_HI   = 14'd800;
    localparam logic [PULSE_W-1:0] ONE_LO    = 14'd1400;
    localparam logic [PULSE_W-1:0] ONE_HI    = 14'd1800;
    localparam logic [PULSE_W-1:0] REP_LO    = 14'd2200;
    localparam logic [PULSE_W-1:0] REP_HI    = 14'd2600;
    localparam logic [PULSE_W-1:0] LEADER_LO = 14'd4200;
    localparam logic [PULSE_W-1:0] LEADER_HI = 14'd4700;

    localparam logic [7:0] DEV_ADDR_RST = 8'd0;
    localparam logic [3:0] TIMEOUT_RST  = 4'd14;

    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_q_push;

    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_q_head;
endpackage

@@ hw/rtl/nir_in_if.sv @@
`timescale 1ns / 1ps
interface nir_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [13:0] pulse_us;

    modport source (output valid, output action, output pulse_us, input ready);
    modport sink (input valid, input action, input pulse_us, output ready);
endinterface

@@ hw/rtl/nir_out_if.sv @@
`timescale 1ns / 1ps
interface nir_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic [7:0] repeat_count;
    logic       frame_active;

    modport source (output valid, output key_code, output repeat_count,
                    output frame_active, input ready);
    modport sink (input valid, input key_code, input repeat_count,
                  input frame_active, output ready);
endinterface

@@ hw/rtl/nir_front.sv @@
`timescale 1ns / 1ps
module nir_front
    import nir_pkg::*;
(
    nir_in_if.sink  i_in,
    input  logic    i_full,
    output t_q_push o_push
);
    t_evt evt;
    t_action act;

    // Pulse windows are disjoint, so the class does not depend on frame state.
    always_comb begin
        act = t_action'(i_in.action);
        unique case (act)
            ACT_TICK: evt = EVT_TICK;
            ACT_RISE: evt = EVT_RISE;
            ACT_SCAN: evt = EVT_SCAN;
            ACT_FALL: begin
                priority if (i_in.pulse_us > ZERO_LO && i_in.pulse_us < ZERO_HI) begin
                    evt = EVT_ZERO;
                end else if (i_in.pulse_us > ONE_LO && i_in.pulse_us < ONE_HI) begin
                    evt = EVT_ONE;
                end else if (i_in.pulse_us > REP_LO && i_in.pulse_us < REP_HI) begin
                    evt = EVT_REPEAT;
                end else if (i_in.pulse_us > LEADER_LO && i_in.pulse_us < LEADER_HI) begin
                    evt = EVT_LEADER;
                end else begin
                    evt = EVT_FALL_OTHER;
                end
            end
            default: evt = EVT_FALL_OTHER;
        endcase
    end

    assign i_in.ready   = !i_full;
    assign o_push.valid = i_in.valid && !i_full;
    assign o_push.evt   = evt;
endmodule

@@ hw/rtl/nir_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nir_queue
    import nir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    output logic    o_full,
    output t_q_head o_head,
    input  logic    i_pop
);
    t_evt       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_pop;

    assign do_pop = i_pop && (r_count != 2'd0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (do_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.evt;
        end
    end

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.evt   = r_mem[r_rd_ptr];

    `ASSERT_NEVER(a_q_count_range, i_clk, i_rst_n, r_count == 2'd3, "queue count out of range")
    `ASSERT_NEVER(a_q_no_overflow, i_clk, i_rst_n, i_push.valid && o_full, "push into full queue")
    `ASSERT_NEVER(a_q_no_underflow, i_clk, i_rst_n, i_pop && !o_head.valid, "pop from empty queue")
endmodule

@@ hw/rtl/nir_back.sv @@
`timescale 1ns / 1ps
module nir_back
    import nir_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_head          i_head,
    output logic             o_pop,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    nir_out_if.source        o_out
);
    logic [7:0]  r_dev_addr;
    logic [3:0]  r_timeout;
    logic        r_leader;
    logic        r_hp;
    logic        r_fd;
    logic [3:0]  r_tick;
    logic [31:0] r_bits;
    logic [7:0]  r_rep;
    logic        r_out_valid;
    logic [7:0]  r_out_key;
    logic [7:0]  r_out_rep;
    logic        r_out_active;

    logic        n_leader;
    logic        n_hp;
    logic        n_fd;
    logic [3:0]  n_tick;
    logic [31:0] n_bits;
    logic [7:0]  n_rep;
    logic [7:0]  n_key;
    logic        pop;
    logic        frame_ok;

    assign pop = i_head.valid && (!r_out_valid || o_out.ready);
    assign frame_ok = (r_bits[31:24] == ~r_bits[23:16]) && (r_bits[31:24] == r_dev_addr)
                      && (r_bits[15:8] == ~r_bits[7:0]);

    always_comb begin
        n_leader = r_leader;
        n_hp     = r_hp;
        n_fd     = r_fd;
        n_tick   = r_tick;
        n_bits   = r_bits;
        n_rep    = r_rep;
        n_key    = 8'd0;
        if (pop) begin
            unique case (i_head.evt)
                EVT_TICK: begin
                    if (r_leader) begin
                        n_hp = 1'b0;
                        if (r_tick == 4'd0) begin
                            n_fd = 1'b1;
                        end
                        if (r_tick < r_timeout) begin
                            n_tick = r_tick + 4'd1;
                        end else begin
                            n_leader = 1'b0;
                            n_tick   = 4'd0;
                        end
                    end
                end
                EVT_RISE: n_hp = 1'b1;
                EVT_ZERO: begin
                    if (r_hp && r_leader) begin
                        n_bits = {r_bits[30:0], 1'b0};
                    end
                    n_hp = 1'b0;
                end
                EVT_ONE: begin
                    if (r_hp && r_leader) begin
                        n_bits = {r_bits[30:0], 1'b1};
                    end
                    n_hp = 1'b0;
                end
                EVT_REPEAT: begin
                    if (r_hp && r_leader) begin
                        n_rep  = r_rep + 8'd1;
                        n_tick = 4'd0;
                    end
                    n_hp = 1'b0;
                end
                EVT_LEADER: begin
                    if (r_hp && !r_leader) begin
                        n_leader = 1'b1;
                        n_rep    = 8'd0;
                    end
                    n_hp = 1'b0;
                end
                EVT_FALL_OTHER: n_hp = 1'b0;
                EVT_SCAN: begin
                    if (r_fd) begin
                        n_fd  = 1'b0;
                        n_rep = 8'd0;
                        if (frame_ok) begin
                            n_key    = r_bits[15:8];
                            n_leader = 1'b0;
                            n_hp     = 1'b0;
                            n_tick   = 4'd0;
                            n_bits   = 32'd0;
                        end
                    end
                end
                default: n_hp = r_hp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEV_ADDR: r_dev_addr <= i_cfg_data;
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[3:0];
                default:      r_timeout  <= r_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader    <= 1'b0;
            r_hp        <= 1'b0;
            r_fd        <= 1'b0;
            r_tick      <= 4'd0;
            r_bits      <= 32'd0;
            r_rep       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_leader <= n_leader;
            r_hp     <= n_hp;
            r_fd     <= n_fd;
            r_tick   <= n_tick;
            r_bits   <= n_bits;
            r_rep    <= n_rep;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_key    <= n_key;
            r_out_rep    <= n_rep;
            r_out_active <= n_leader;
        end
    end

    assign o_pop              = pop;
    assign o_out.valid        = r_out_valid;
    assign o_out.key_code     = r_out_key;
    assign o_out.repeat_count = r_out_rep;
    assign o_out.frame_active = r_out_active;
endmodule

@@ hw/rtl/nec_ir_remote_decoder.sv @@
`timescale 1ns / 1ps
// An accepted input transaction is written into the event queue, and the back end
// registers its result when it pops the event. Throughput: one transaction per cycle
// while the output is ready; the frame state update in the back end is one registered
// step, and a two-entry event queue decouples it from the input.
// Reset is synchronous and active low: it clears all frame state and the queue,
// and sets the expected address to 0 and the timeout to 14 ticks.
module nec_ir_remote_decoder
    import nir_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    nir_in_if.sink           i_in,
    nir_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);
    t_q_push push;
    t_q_head head;
    logic    full;
    logic    pop;

    nir_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push)
    );

    nir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    nir_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );
endmodule

@@ test/nec_frame_checker.sv @@
`timescale 1ns / 1ps
module nec_frame_checker
    import nir_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    nir_in_if                i_in,
    nir_out_if               i_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_results,
    output int               o_keys
);
    typedef struct packed {
        logic [7:0] key_code;
        logic [7:0] repeat_count;
        logic       frame_active;
    } t_key_report;

    logic [7:0]  dev_addr;
    logic [3:0]  timeout_ticks;

    logic        got_leader;
    logic        pulse_open;
    logic        frame_ready;
    logic [3:0]  overflow_cnt;
    logic [31:0] code_word;
    logic [7:0]  repeat_cnt;

    t_key_report key_reports_q[$];
    int          err_count;
    int          result_count;
    int          key_count;

    assign o_errors  = err_count;
    assign o_results = result_count;
    assign o_keys    = key_count;

    function automatic bit in_window(input logic [13:0] len, input logic [13:0] lo,
                                     input logic [13:0] hi);
        return len > lo && len < hi;
    endfunction

    // Applies one event to the frame state and returns the report the block must give.
    function automatic t_key_report decode_event(input t_action act, input logic [13:0] len);
        t_key_report rep;
        logic [7:0]  key;
        key = 8'd0;
        case (act)
            ACT_TICK: begin
                if (got_leader) begin
                    pulse_open = 1'b0;
                    if (overflow_cnt == 4'd0)
                        frame_ready = 1'b1;
                    if (overflow_cnt < timeout_ticks) begin
                        overflow_cnt = overflow_cnt + 4'd1;
                    end else begin
                        got_leader   = 1'b0;
                        overflow_cnt = 4'd0;
                    end
                end
            end
            ACT_RISE: begin
                pulse_open = 1'b1;
            end
            ACT_FALL: begin
                if (pulse_open) begin
                    if (got_leader) begin
                        if (in_window(len, ZERO_LO, ZERO_HI)) begin
                            code_word = {code_word[30:0], 1'b0};
                        end else if (in_window(len, ONE_LO, ONE_HI)) begin
                            code_word = {code_word[30:0], 1'b1};
                        end else if (in_window(len, REP_LO, REP_HI)) begin
                            repeat_cnt   = repeat_cnt + 8'd1;
                            overflow_cnt = 4'd0;
                        end
                    end else if (in_window(len, LEADER_LO, LEADER_HI)) begin
                        got_leader = 1'b1;
                        repeat_cnt = 8'd0;
                    end
                end
                pulse_open = 1'b0;
            end
            default: begin
                if (frame_ready) begin
                    if (code_word[31:24] == ~code_word[23:16]
                            && code_word[31:24] == dev_addr
                            && code_word[15:8] == ~code_word[7:0]) begin
                        key          = code_word[15:8];
                        got_leader   = 1'b0;
                        pulse_open   = 1'b0;
                        frame_ready  = 1'b0;
                        overflow_cnt = 4'd0;
                        code_word    = 32'd0;
                    end
                    if (key == 8'd0 || !got_leader) begin
                        frame_ready = 1'b0;
                        repeat_cnt  = 8'd0;
                    end
                end
            end
        endcase
        rep.key_code     = key;
        rep.repeat_count = repeat_cnt;
        rep.frame_active = got_leader;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_key_report want;
        t_key_report got;
        if (!i_rst_n) begin
            dev_addr      = DEV_ADDR_RST;
            timeout_ticks = TIMEOUT_RST;
            got_leader    = 1'b0;
            pulse_open    = 1'b0;
            frame_ready   = 1'b0;
            overflow_cnt  = 4'd0;
            code_word     = 32'd0;
            repeat_cnt    = 8'd0;
            key_reports_q.delete();
            err_count     = 0;
            result_count  = 0;
            key_count     = 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DEV_ADDR)
                    dev_addr = i_cfg_data;
                else
                    timeout_ticks = i_cfg_data[3:0];
            end
            if (i_out.valid && i_out.ready) begin
                got.key_code     = i_out.key_code;
                got.repeat_count = i_out.repeat_count;
                got.frame_active = i_out.frame_active;
                result_count++;
                if (key_reports_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    err_count++;
                end else begin
                    want = key_reports_q.pop_front();
                    if (want.key_code != 8'd0)
                        key_count++;
                    if (got.key_code !== want.key_code) begin
                        $error("key_code mismatch: expected %0d, actual %0d",
                               want.key_code, got.key_code);
                        err_count++;
                    end
                    if (got.repeat_count !== want.repeat_count) begin
                        $error("repeat_count mismatch: expected %0d, actual %0d",
                               want.repeat_count, got.repeat_count);
                        err_count++;
                    end
                    if (got.frame_active !== want.frame_active) begin
                        $error("frame_active mismatch: expected %0d, actual %0d",
                               want.frame_active, got.frame_active);
                        err_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                key_reports_q.push_back(decode_event(t_action'(i_in.action), i_in.pulse_us));
            o_pending <= key_reports_q.size();
        end
    end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import nir_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 105;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we  = 1'b0;
    logic             cfg_idx = CFG_DEV_ADDR;
    logic [CFG_W-1:0] cfg_data = '0;

    nir_in_if  in_ch();
    nir_out_if out_ch();

    int   errors;
    int   pending;
    int   results;
    int   keys;
    int   sent;
    int   cycles;
    int   stall_left;
    bit   src_gaps;
    bit   sink_gaps;
    logic [7:0] cur_id;

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.action   = ACT_TICK;
        in_ch.pulse_us = '0;
        out_ch.ready   = 1'b0;
        sent           = 0;
        cycles         = 0;
        stall_left     = 0;
        src_gaps       = 1'b0;
        sink_gaps      = 1'b0;
        cur_id         = DEV_ADDR_RST;
    end

    always #5 i_clk = ~i_clk;

    nec_ir_remote_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    nec_frame_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_keys     (keys)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [13:0] pick_len(input logic [13:0] lo, input logic [13:0] hi);
        return 14'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    endfunction

    function automatic logic [13:0] any_len();
        return 14'($urandom_range(0, 9999));
    endfunction

    task automatic push_event(input t_action act, input logic [13:0] len);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.pulse_us <= len;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic send_pulse(input logic [13:0] len);
        push_event(ACT_RISE, any_len());
        push_event(ACT_FALL, len);
    endtask

    task automatic settle(input int quiet);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (quiet) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [7:0] id, input logic [3:0] ticks);
        settle(4);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DEV_ADDR;
        cfg_data <= id;
        @(posedge i_clk);
        cfg_idx  <= CFG_TIMEOUT;
        cfg_data <= {4'd0, ticks};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_id = id;
    endtask

    task automatic send_frame();
        logic [7:0]  addr;
        logic [7:0]  naddr;
        logic [7:0]  cmd;
        logic [7:0]  ncmd;
        logic [31:0] word;
        int          nbits;
        int          ticks;
        addr  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : cur_id;
        naddr = ($urandom_range(0, 7) == 0) ? 8'($urandom) : ~addr;
        cmd   = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
        ncmd  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : ~cmd;
        word  = {addr, naddr, cmd, ncmd};
        nbits = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : 32;
        ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 17) : $urandom_range(1, 2);
        send_pulse(pick_len(LEADER_LO, LEADER_HI));
        for (int i = 0; i < nbits; i++)
            send_pulse(word[31 - i] ? pick_len(ONE_LO, ONE_HI) : pick_len(ZERO_LO, ZERO_HI));
        repeat (ticks) push_event(ACT_TICK, any_len());
        push_event(ACT_SCAN, any_len());
    endtask

    task automatic send_repeats();
        int count;
        count = $urandom_range(1, 6);
        send_pulse(pick_len(LEADER_LO, LEADER_HI));
        repeat (count) begin
            send_pulse(pick_len(REP_LO, REP_HI));
            push_event(ACT_TICK, any_len());
        end
        if ($urandom_range(0, 1) == 0)
            push_event(ACT_SCAN, any_len());
    endtask

    task automatic send_noise();
        logic [13:0] bounds[8];
        logic [13:0] len;
        int          count;
        bounds = '{ZERO_LO, ZERO_HI, ONE_LO, ONE_HI, REP_LO, REP_HI, LEADER_LO, LEADER_HI};
        count  = $urandom_range(4, 12);
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: len = any_len();
                1: len = bounds[$urandom_range(0, 7)];
                2: len = ($urandom_range(0, 1) == 0) ? pick_len(ZERO_LO, ZERO_HI)
                                                     : pick_len(ONE_LO, ONE_HI);
                default: len = ($urandom_range(0, 1) == 0) ? pick_len(REP_LO, REP_HI)
                                                           : pick_len(LEADER_LO, LEADER_HI);
            endcase
            push_event(t_action'($urandom_range(0, 3)), len);
        end
    endtask

    initial begin
        int          pick;
        int          phase_end;
        logic [7:0]  ids[PHASES];
        logic [3:0]  limits[PHASES];
        ids    = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        limits = '{4'd15, 4'd1, 4'd0, 4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
                   4'($urandom_range(2, 15))};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner cases under the reset settings.
        push_event(ACT_SCAN, 14'd0);
        push_event(ACT_TICK, 14'd9999);
        push_event(ACT_FALL, pick_len(LEADER_LO, LEADER_HI));
        send_pulse(LEADER_LO);
        send_pulse(LEADER_HI);
        send_pulse(pick_len(LEADER_LO, LEADER_HI));
        send_pulse(ZERO_LO);
        send_pulse(ZERO_LO + 14'd1);
        send_pulse(ONE_HI - 14'd1);
        send_pulse(REP_LO + 14'd1);
        send_pulse(14'd9999);
        send_pulse(14'd0);
        push_event(ACT_TICK, 14'd0);
        push_event(ACT_SCAN, 14'd9999);
        push_event(ACT_TICK, 14'd0);

        for (int p = 0; p < PHASES; p++) begin
            load_settings(ids[p], limits[p]);
            src_gaps  = (p != 2 && p != PHASES - 1);
            sink_gaps <= (p != 2 && p != PHASES - 1);
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    send_frame();
                else if (pick < 17)
                    send_repeats();
                else
                    send_noise();
            end
        end

        settle(10);
        $display("Sent %0d input transactions and checked %0d results, %0d with a decoded key,",
                 sent, results, keys);
        $display("across %0d register settings including the timeout extremes.", PHASES + 1);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
